// ----- rtl/core/prnp_pkg.sv -----
// Shared types and constants for the palette reduce and nibble pack block.
// No dependencies; imported by every module of the block.
`default_nettype none

package prnp_pkg;

  localparam int NUM_ENTRIES_DEF = 144;
  localparam int FIRST_VALUE_DEF = 64;
  localparam int MAX_SLOTS_DEF   = 15;

  localparam int SLOT_W  = 4;
  localparam int COLOR_W = 24;
  localparam int PIX_W   = 8;

  localparam logic [SLOT_W-1:0] OVERFLOW_SLOT = 4'd15;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_PIXEL   = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              inserted;
    logic [SLOT_W-1:0] used;
  } slot_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/prnp_map_mem.sv -----
// Index-to-slot map: synchronous memory, one write port, two registered read ports.
// Per-entry valid bits give the all-zero reset and clear. Uses prnp_pkg.
`default_nettype none

module prnp_map_mem
  import prnp_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [SLOT_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr_a,
  input  wire logic              rd_ok_a,
  input  wire logic [IDX_W-1:0]  rd_addr_b,
  input  wire logic              rd_ok_b,
  output logic      [SLOT_W-1:0] rd_data_a,
  output logic      [SLOT_W-1:0] rd_data_b
);

  logic [SLOT_W-1:0]      mem_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_r;
  logic [SLOT_W-1:0]      raw_a_r;
  logic [SLOT_W-1:0]      raw_b_r;
  logic                   hit_a_r;
  logic                   hit_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      raw_a_r <= mem_r[rd_addr_a];
      raw_b_r <= mem_r[rd_addr_b];
    end
  end

  // reads run on every accept, also with a palette write; only pixel pairs, which never write, use the data
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else if (rd_en) begin
      hit_a_r <= rd_ok_a && vld_r[rd_addr_a];
      hit_b_r <= rd_ok_b && vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = hit_a_r ? raw_a_r : '0;
  assign rd_data_b = hit_b_r ? raw_b_r : '0;

endmodule

`default_nettype wire

// ----- rtl/core/prnp_slot_table.sv -----
// Slot color table with parallel first-match compare and insertion.
// Uses prnp_pkg.
`default_nettype none

module prnp_slot_table
  import prnp_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clr,
  input  wire logic               upd_en,
  input  wire logic [COLOR_W-1:0] color,
  output slot_res_t               res,
  output logic      [SLOT_W-1:0]  count
);

  logic [COLOR_W-1:0] colors_r [MAX_SLOTS];
  logic [SLOT_W-1:0]  count_r;
  logic [SLOT_W-1:0]  count_nxt;
  logic [MAX_SLOTS-1:0] hit;
  logic                 found;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 do_ins;

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      hit[k] = (SLOT_W'(k) < count_r) && (colors_r[k] == color);
    end
  end

  always_comb begin
    found    = 1'b0;
    hit_slot = '0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        found    = 1'b1;
        hit_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    do_ins       = !found && (count_r < SLOT_W'(MAX_SLOTS));
    res.inserted = do_ins;
    if (found) begin
      res.slot = hit_slot;
    end else if (do_ins) begin
      res.slot = count_r;
    end else begin
      res.slot = OVERFLOW_SLOT;
    end
    res.used = count_r + SLOT_W'(do_ins);
  end

  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (upd_en) begin
      count_nxt = res.used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && do_ins) begin
      colors_r[count_r[SLOT_W-1:0]] <= color;
    end
  end

  assign count = count_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOT_W'(MAX_SLOTS))
    else $error("slot count above limit");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && !clr && do_ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insertion did not advance slot count");

  a_clr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (count_r == '0))
    else $error("clear left slots in use");

  a_no_ins_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> !do_ins)
    else $error("insert on matching color");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/palette_reduce_and_nibble_pack.sv -----
// Palette reduction to 15 color slots and 4bpp nibble packing, top level.
// Uses prnp_pkg, prnp_slot_table and prnp_map_mem.
//
// Input requests arrive on in_* with the kind in in_tuser: clear, palette entry
// or pixel pair. Each request yields exactly one result on out_*.
// A palette entry is compared against all used slots in the accept cycle;
// the slot table and the index map are updated at that same edge.
// A pixel pair reads the index map at both pixel addresses in the accept
// cycle; the registered read data forms the packed byte in the cycle after.
// out_tvalid rises in the cycle after accept. One request per cycle is
// sustained while out_tready is high.
// A stalled out_tready holds the result; in_tready is low while reset is
// asserted and while a result waits and out_tready is low.
// After reset no slot is used and every map entry reads as zero; there is no
// clearing pass, requests are taken in the first cycle after reset.
`default_nettype none

module palette_reduce_and_nibble_pack
  import prnp_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int FIRST_VALUE = FIRST_VALUE_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // entry_index[7:0], color_red[15:8], color_green[23:16], color_blue[31:24],
  // pixel_first[39:32], pixel_second[47:40]
  input  wire logic [47:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // packed_byte[7:0], slot[11:8], inserted[12], colors_used[16:13], zero[23:17]
  output logic      [23:0] out_tdata
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic              accept;
  logic [PIX_W-1:0]  entry_index;
  logic [COLOR_W-1:0] color;
  logic [PIX_W-1:0]  pix_a;
  logic [PIX_W-1:0]  pix_b;
  logic              is_clr;
  logic              is_pal;
  logic              is_pix;
  logic [PIX_W:0]    off_a;
  logic [PIX_W:0]    off_b;
  logic              ok_a;
  logic              ok_b;
  logic              wr_ok;
  slot_res_t         res;
  logic [SLOT_W-1:0] count;
  logic [SLOT_W-1:0] map_a;
  logic [SLOT_W-1:0] map_b;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              pix_r;
  logic [SLOT_W-1:0] slot_r;
  logic              ins_r;
  logic [SLOT_W-1:0] used_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic              ins_nxt;
  logic [SLOT_W-1:0] used_nxt;

  assign in_tready   = rst_n && (!out_valid_r || out_tready);
  assign accept      = in_tvalid && in_tready;
  assign entry_index = in_tdata[7:0];
  assign color       = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
  assign pix_a       = in_tdata[39:32];
  assign pix_b       = in_tdata[47:40];

  always_comb begin
    is_clr = 1'b0;
    is_pal = 1'b0;
    is_pix = 1'b0;
    unique case (in_tuser)
      MODE_CLEAR:   is_clr = 1'b1;
      MODE_PALETTE: is_pal = 1'b1;
      MODE_PIXEL:   is_pix = 1'b1;
      default:      ;
    endcase
  end

  assign off_a = {1'b0, pix_a} - (PIX_W+1)'(FIRST_VALUE);
  assign off_b = {1'b0, pix_b} - (PIX_W+1)'(FIRST_VALUE);
  assign ok_a  = ({1'b0, pix_a} >= (PIX_W+1)'(FIRST_VALUE)) &&
                 (off_a < (PIX_W+1)'(NUM_ENTRIES));
  assign ok_b  = ({1'b0, pix_b} >= (PIX_W+1)'(FIRST_VALUE)) &&
                 (off_b < (PIX_W+1)'(NUM_ENTRIES));
  assign wr_ok = {1'b0, entry_index} < (PIX_W+1)'(NUM_ENTRIES);

  prnp_slot_table #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (accept && is_clr),
    .upd_en (accept && is_pal),
    .color  (color),
    .res    (res),
    .count  (count)
  );

  prnp_map_mem #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept && is_clr),
    .wr_en     (accept && is_pal && wr_ok),
    .wr_addr   (entry_index[IDX_W-1:0]),
    .wr_data   (res.slot),
    .rd_en     (accept),
    .rd_addr_a (off_a[IDX_W-1:0]),
    .rd_ok_a   (ok_a && is_pix),
    .rd_addr_b (off_b[IDX_W-1:0]),
    .rd_ok_b   (ok_b && is_pix),
    .rd_data_a (map_a),
    .rd_data_b (map_b)
  );

  always_comb begin
    slot_nxt = '0;
    ins_nxt  = 1'b0;
    used_nxt = count;
    if (is_clr) begin
      used_nxt = '0;
    end else if (is_pal) begin
      slot_nxt = res.slot;
      ins_nxt  = res.inserted;
      used_nxt = res.used;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pix_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        pix_r <= is_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= slot_nxt;
      ins_r  <= ins_nxt;
      used_r <= used_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  // map read data holds while stalled: the memory reads only on accept
  assign out_tdata  = {7'd0, used_r, ins_r, slot_r,
                       (pix_r ? {map_a, map_b} : 8'd0)};

endmodule

`default_nettype wire
